>>> rtl/csm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the CSR sparse matrix-vector block.
package csm_pkg;

	localparam int unsigned MAX_N    = 1024;
	localparam int unsigned STORE_AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	localparam int unsigned FUNC_W = 2;
	localparam int unsigned IDX_W  = 10;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned VLEN_W = 11;
	localparam int unsigned ACC_W  = 64;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;

	localparam int unsigned PADDR_W = 3;
	localparam logic        REG_VLEN = 1'b0;
	localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd1024;

	typedef logic [FUNC_W-1:0] func_t;
	localparam func_t FUNC_LOAD  = 2'd0;
	localparam func_t FUNC_NZ    = 2'd1;
	localparam func_t FUNC_CLOSE = 2'd2;

	// one queued multiply-accumulate; a close is a zero product that ends the row
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] vec;
		logic                    last;
	} qent_t;

endpackage

>>> rtl/csr_sparse_matvec.sv
`timescale 1ns / 1ps
// Top level of the CSR sparse matrix-vector multiply block.
// Path of a row's ending word: front stage register, queue, then product, row-end and output registers.
// Throughput: one word per cycle while the queue has room; the multiply-accumulate loop holds one register, acc_q.
// Output backpressure stalls the back end; a 4-deep queue keeps the front taking words.
// Reset: asynchronous, clears control, accumulator, row counter; vector_length = 1024.
// The vector store holds no reset value and needs no clearing pass.
module csr_sparse_matvec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,  // index[9:0], value[41:10], zero pad
	input  logic [1:0]                    s_tuser,  // func[1:0]
	input  logic                          s_tlast,  // last_in_row
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [47:0]                   m_tdata,  // row_value[31:0], row_number[41:32], pad
	output logic [0:0]                    m_tuser,  // saturated[0]
	output logic                          m_tlast,  // last_row
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [csm_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [csm_pkg::VLEN_W-1:0] vlen_q;
	logic                       cfg_wr;

	logic           fq_valid;
	logic           fq_ready;
	csm_pkg::qent_t fq_data;
	logic           qb_valid;
	logic           qb_ready;
	csm_pkg::qent_t qb_data;

	logic [csm_pkg::VAL_W-1:0] row_value;
	logic [csm_pkg::IDX_W-1:0] row_number;
	logic                      row_sat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == csm_pkg::REG_VLEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= csm_pkg::VLEN_RESET;
		end else if (cfg_wr) begin
			vlen_q <= pwdata[csm_pkg::VLEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == csm_pkg::REG_VLEN) ? 32'(vlen_q) : '0;

	csm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tuser),
		.in_index (s_tdata[9:0]),
		.in_value (s_tdata[41:10]),
		.in_last  (s_tlast),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	csm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	csm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (qb_valid),
		.q_ready       (qb_ready),
		.q_data        (qb_data),
		.vector_length (vlen_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_value     (row_value),
		.out_row       (row_number),
		.out_last      (m_tlast),
		.out_sat       (row_sat)
	);

	assign m_tdata = {6'd0, row_number, row_value};
	assign m_tuser = row_sat;

endmodule

>>> rtl/csm_front.sv
`timescale 1ns / 1ps
// Front end: accepts words, owns the vector store, classifies and fetches operands.
module csm_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  csm_pkg::func_t               in_func,
	input  logic [csm_pkg::IDX_W-1:0]    in_index,
	input  logic [csm_pkg::VAL_W-1:0]    in_value,
	input  logic                         in_last,
	output logic                         q_valid,
	input  logic                         q_ready,
	output csm_pkg::qent_t               q_data
);

	logic [csm_pkg::VAL_W-1:0] mem [csm_pkg::MAX_N];

	logic                         s1_valid_q;
	logic [csm_pkg::VAL_W-1:0]    value_s1;
	logic [csm_pkg::VAL_W-1:0]    rdata_s1;
	logic                         last_s1;
	logic                         zero_s1;

	logic                         in_acc;
	logic                         in_range;
	logic                         take;
	logic                         is_close;
	logic                         wr_en;
	logic [csm_pkg::STORE_AW-1:0] addr;

	assign in_ready = !s1_valid_q || q_ready;
	assign in_acc   = in_valid && in_ready;
	assign in_range = 32'(in_index) < csm_pkg::MAX_N;
	assign addr     = in_index[csm_pkg::STORE_AW-1:0];

	always_comb begin
		take     = 1'b0;
		is_close = 1'b0;
		wr_en    = 1'b0;
		unique case (in_func)
			csm_pkg::FUNC_LOAD: begin
				wr_en = in_acc && in_range;
			end
			csm_pkg::FUNC_NZ: begin
				take = in_acc;
			end
			csm_pkg::FUNC_CLOSE: begin
				take     = in_acc;
				is_close = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= in_value;
		end
		if (take && !is_close) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_s1 <= is_close ? '0 : in_value;
			last_s1  <= is_close ? 1'b1 : in_last;
			zero_s1  <= is_close || !in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (q_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	assign q_valid      = s1_valid_q;
	assign q_data.value = value_s1;
	assign q_data.vec   = zero_s1 ? '0 : rdata_s1;
	assign q_data.last  = last_s1;

	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_func == csm_pkg::FUNC_CLOSE |=> q_valid && q_data.last && q_data.value == '0)
		else $error("close word did not reach queue stage as zero end-of-row");

endmodule

>>> rtl/csm_queue.sv
`timescale 1ns / 1ps
// Short register queue between front and back end.
module csm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  csm_pkg::qent_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output csm_pkg::qent_t pop_data
);

	csm_pkg::qent_t entry_q [csm_pkg::QDEPTH];

	logic [csm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [csm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [csm_pkg::QCNT_W-1:0] cnt_q;
	logic                       push;
	logic                       pop;

	assign push_ready = cnt_q != csm_pkg::QCNT_W'(csm_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= csm_pkg::QCNT_W'(csm_pkg::QDEPTH))
		else $error("queue count beyond depth");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

>>> rtl/csm_back.sv
`timescale 1ns / 1ps
// Back end: multiply, saturating accumulate, round and emit row results.
module csm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  csm_pkg::qent_t              q_data,
	input  logic [csm_pkg::VLEN_W-1:0]  vector_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [csm_pkg::VAL_W-1:0]   out_value,
	output logic [csm_pkg::IDX_W-1:0]   out_row,
	output logic                        out_last,
	output logic                        out_sat
);

	localparam logic signed [csm_pkg::ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [csm_pkg::ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [csm_pkg::ACC_W-1:0] OUT_HI  = 64'sh0000_7FFF_FFFF_8000;
	localparam logic signed [csm_pkg::ACC_W-1:0] OUT_LO  = 64'shFFFF_7FFF_FFFF_8000;
	localparam logic signed [csm_pkg::ACC_W-1:0] HALF    = 64'sh0000_0000_0000_8000;

	logic adv;

	logic                               s2_valid_q;
	logic signed [csm_pkg::ACC_W-1:0]   prod_s2;
	logic                               last_s2;
	logic signed [csm_pkg::ACC_W-1:0]   prod;

	logic signed [csm_pkg::ACC_W-1:0]   acc_q;
	logic                               acc_sat_q;
	logic signed [csm_pkg::ACC_W:0]     sum_w;
	logic signed [csm_pkg::ACC_W-1:0]   acc_nxt;
	logic                               ovf;

	logic                               e_valid_s3;
	logic signed [csm_pkg::ACC_W-1:0]   e_sum_s3;
	logic                               e_sat_s3;

	logic signed [csm_pkg::ACC_W-1:0]   rnd;
	logic [csm_pkg::VAL_W-1:0]          rv;
	logic                               rv_sat;

	logic                               out_valid_q;
	logic [csm_pkg::IDX_W-1:0]          row_cnt_q;
	logic [csm_pkg::VLEN_W-1:0]         row_inc;
	logic                               is_last;

	assign adv     = !out_valid_q || out_ready;
	assign q_ready = adv;

	assign prod = q_data.value * q_data.vec;

	always_ff @(posedge clk) begin
		if (adv && q_valid) begin
			prod_s2 <= prod;
			last_s2 <= q_data.last;
		end
	end

	assign sum_w   = {acc_q[csm_pkg::ACC_W-1], acc_q} + {prod_s2[csm_pkg::ACC_W-1], prod_s2};
	assign ovf     = sum_w[csm_pkg::ACC_W] != sum_w[csm_pkg::ACC_W-1];
	assign acc_nxt = ovf ? (prod_s2[csm_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX)
	                     : sum_w[csm_pkg::ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (adv && s2_valid_q && last_s2) begin
			e_sum_s3 <= acc_nxt;
			e_sat_s3 <= acc_sat_q || ovf;
		end
	end

	// output rounding: half up, then clamp to Q16.16
	always_comb begin
		rnd    = e_sum_s3 + HALF;
		rv     = rnd[csm_pkg::VAL_W+15:16];
		rv_sat = 1'b0;
		if (e_sum_s3 >= OUT_HI) begin
			rv     = 32'h7FFF_FFFF;
			rv_sat = 1'b1;
		end else if (e_sum_s3 < OUT_LO) begin
			rv     = 32'h8000_0000;
			rv_sat = 1'b1;
		end
	end

	assign row_inc = {1'b0, row_cnt_q} + 1'b1;
	assign is_last = row_inc == vector_length;

	always_ff @(posedge clk) begin
		if (adv && e_valid_s3) begin
			out_value <= rv;
			out_row   <= row_cnt_q;
			out_last  <= is_last;
			out_sat   <= e_sat_s3 || rv_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			e_valid_s3  <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			acc_sat_q   <= 1'b0;
			row_cnt_q   <= '0;
		end else if (adv) begin
			s2_valid_q  <= q_valid;
			e_valid_s3  <= s2_valid_q && last_s2;
			out_valid_q <= e_valid_s3;
			if (s2_valid_q) begin
				if (last_s2) begin
					acc_q     <= '0;
					acc_sat_q <= 1'b0;
				end else begin
					acc_q     <= acc_nxt;
					acc_sat_q <= acc_sat_q || ovf;
				end
			end
			if (e_valid_s3) begin
				row_cnt_q <= is_last ? '0 : row_inc[csm_pkg::IDX_W-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && s2_valid_q && last_s2 |=> acc_q == '0 && !acc_sat_q)
		else $error("accumulator not cleared at end of row");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		adv && e_valid_s3 && is_last |=> row_cnt_q == '0 && out_valid && out_last)
		else $error("row counter did not wrap after last row");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for csr_sparse_matvec: directed and random word streams checked by a row-sum predictor.
module tb;

	localparam int             LIMIT_CYCLES = 200000;
	localparam int             DRAIN_CYCLES = 8;
	localparam csm_pkg::func_t FUNC_UNUSED  = 2'd3;
	localparam logic [csm_pkg::PADDR_W-1:0] VLEN_ADDR =
		csm_pkg::PADDR_W'(4 * csm_pkg::REG_VLEN);
	localparam longint OUT_HI = 64'sh0000_7FFF_FFFF_8000;
	localparam longint OUT_LO = -64'sh0000_8000_0000_8000;

	typedef struct {
		bit [31:0] value;
		bit [9:0]  number;
		bit        last;
		bit        sat;
	} row_t;

	// Predicts row sums from accepted words and checks them in order.
	class row_sum_checker;
		bit [31:0]  vec_mem [csm_pkg::MAX_N];
		longint     acc;
		bit [9:0]   row_cnt;
		bit         row_sat;
		bit [10:0]  vlen;
		row_t       rows_due [$];
		int         fails;
		int         rows_checked;
		int         sat_rows;

		function new();
			acc = 0;
			row_cnt = '0;
			row_sat = 1'b0;
			vlen = csm_pkg::VLEN_RESET;
		endfunction

		function void set_length(bit [10:0] v);
			vlen = v;
		endfunction

		function int pending();
			return rows_due.size();
		endfunction

		function void close_row();
			row_t   r;
			longint t;
			r.sat = row_sat;
			if (acc >= OUT_HI) begin
				r.value = 32'h7FFF_FFFF;
				r.sat = 1'b1;
			end else if (acc < OUT_LO) begin
				r.value = 32'h8000_0000;
				r.sat = 1'b1;
			end else begin
				t = acc + 64'sh8000;
				r.value = t[47:16];
			end
			r.number = row_cnt;
			r.last = (int'(row_cnt) + 1 == int'(vlen));
			rows_due.push_back(r);
			row_cnt = r.last ? 10'd0 : row_cnt + 10'd1;
			acc = 0;
			row_sat = 1'b0;
		endfunction

		function void note_word(csm_pkg::func_t f, bit [9:0] idx, bit [31:0] val, bit last);
			longint             prod;
			logic signed [64:0] sum;
			case (f)
				csm_pkg::FUNC_LOAD: vec_mem[idx] = val;
				csm_pkg::FUNC_NZ: begin
					prod = longint'($signed(val)) * longint'($signed(vec_mem[idx]));
					sum = $signed({acc[63], acc}) + $signed({prod[63], prod});
					if (sum[64] != sum[63]) begin
						acc = sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
						row_sat = 1'b1;
					end else begin
						acc = sum[63:0];
					end
					if (last)
						close_row();
				end
				csm_pkg::FUNC_CLOSE: close_row();
				default: ;
			endcase
		endfunction

		function void check_row(bit [31:0] value, bit [9:0] number, bit last, bit sat);
			row_t r;
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected row word value %h row %0d last %b sat %b",
					$time, value, number, last, sat);
				fails++;
				return;
			end
			r = rows_due.pop_front();
			rows_checked++;
			if (sat)
				sat_rows++;
			if (value !== r.value) begin
				$display("%0t: row_value expected %h actual %h", $time, r.value, value);
				fails++;
			end
			if (number !== r.number) begin
				$display("%0t: row_number expected %0d actual %0d", $time, r.number, number);
				fails++;
			end
			if (last !== r.last) begin
				$display("%0t: last_row expected %b actual %b", $time, r.last, last);
				fails++;
			end
			if (sat !== r.sat) begin
				$display("%0t: saturated expected %b actual %b", $time, r.sat, sat);
				fails++;
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [47:0]                  s_tdata = '0;  // index[9:0], value[41:10], zero pad
	logic [1:0]                   s_tuser = '0;  // func[1:0]
	logic                         s_tlast = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [47:0]                  m_tdata;       // row_value[31:0], row_number[41:32], pad
	logic [0:0]                   m_tuser;       // saturated[0]
	logic                         m_tlast;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [csm_pkg::PADDR_W-1:0]  paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;

	row_sum_checker sb;
	int             tx_idle_pct = 0;
	int             rx_stall_pct = 0;
	int             cycles = 0;
	int             words_sent = 0;
	int             loads_sent = 0;
	bit             written_map [csm_pkg::MAX_N];
	int             written_list [$];

	csr_sparse_matvec u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_row(m_tdata[31:0], m_tdata[41:32], m_tlast, m_tuser[0]);
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	function automatic bit [31:0] q16_value();
		bit [31:0] raw;
		raw = $urandom();
		case ($urandom_range(0, 9))
			8: return raw;
			9: begin
				case ($urandom_range(0, 5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0001_0000;
					3: return 32'hFFFF_0000;
					4: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return 32'($signed(raw) >>> $urandom_range(8, 22));
		endcase
	endfunction

	task automatic send_word(csm_pkg::func_t f, bit [9:0] idx, bit [31:0] val, bit last);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tlast <= last;
		s_tdata <= {6'd0, val, idx};
		do @(posedge clk); while (!s_tready);
		sb.note_word(f, idx, val, last);
		if (f == csm_pkg::FUNC_LOAD) begin
			loads_sent++;
			if (!written_map[idx]) begin
				written_map[idx] = 1'b1;
				written_list.push_back(idx);
			end
		end
		if (f != FUNC_UNUSED)
			words_sent++;
	endtask

	task automatic write_length(bit [10:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= VLEN_ADDR;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_length(v);
	endtask

	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(bit [10:0] vlen, int tx, int rx, int n_words);
		int       sent;
		int       pick;
		int       len;
		bit       broken;
		bit [9:0] idx;
		wait_idle();
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		write_length(vlen);
		sent = 0;
		while (sent < n_words) begin
			pick = $urandom_range(0, 99);
			if (written_list.size() == 0 || pick < 12) begin
				idx = 10'($urandom_range(0, 1023));
				if ($urandom_range(0, 7) == 0)
					idx = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
				send_word(csm_pkg::FUNC_LOAD, idx, q16_value(), 1'($urandom_range(0, 1)));
				sent++;
			end else if (pick < 16) begin
				send_word(FUNC_UNUSED, 10'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
			end else if (pick < 26) begin
				send_word(csm_pkg::FUNC_CLOSE, 10'($urandom()), $urandom(),
					1'($urandom_range(0, 1)));
				sent++;
			end else begin
				len = $urandom_range(1, 6);
				// occasionally leave the row open so the next row or a close ends it
				broken = ($urandom_range(0, 9) == 0);
				for (int k = 0; k < len; k++) begin
					idx = 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
					send_word(csm_pkg::FUNC_NZ, idx, q16_value(), (k == len - 1) && !broken);
					sent++;
				end
			end
		end
		send_word(csm_pkg::FUNC_CLOSE, '0, '0, 1'b0);
		s_tvalid <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: three-row problem, no idling
		write_length(11'd3);
		send_word(csm_pkg::FUNC_LOAD, 10'd0, 32'h8000_0000, 1'b1);
		send_word(csm_pkg::FUNC_LOAD, 10'd1023, 32'h7FFF_FFFF, 1'b0);
		send_word(csm_pkg::FUNC_LOAD, 10'd1, 32'h0001_0000, 1'b0);
		send_word(csm_pkg::FUNC_LOAD, 10'd2, 32'h0000_0001, 1'b0);
		// accumulator overflow, positive then negative
		send_word(csm_pkg::FUNC_NZ, 10'd0, 32'h8000_0000, 1'b0);
		send_word(csm_pkg::FUNC_NZ, 10'd0, 32'h8000_0000, 1'b1);
		send_word(csm_pkg::FUNC_NZ, 10'd0, 32'h7FFF_FFFF, 1'b0);
		send_word(csm_pkg::FUNC_NZ, 10'd0, 32'h7FFF_FFFF, 1'b0);
		send_word(csm_pkg::FUNC_NZ, 10'd0, 32'h7FFF_FFFF, 1'b1);
		// empty row, ignored fields set
		send_word(csm_pkg::FUNC_CLOSE, 10'd1023, 32'hFFFF_FFFF, 1'b1);
		// largest output without saturation, then exactly at the rounding limit
		send_word(csm_pkg::FUNC_NZ, 10'd1023, 32'h0001_0000, 1'b1);
		send_word(csm_pkg::FUNC_NZ, 10'd1, 32'h7FFF_FFFF, 1'b0);
		send_word(csm_pkg::FUNC_NZ, 10'd2, 32'h0000_8000, 1'b1);
		// round half up around zero
		send_word(csm_pkg::FUNC_NZ, 10'd2, 32'h0000_8000, 1'b1);
		send_word(csm_pkg::FUNC_NZ, 10'd2, 32'hFFFF_8000, 1'b1);
		send_word(csm_pkg::FUNC_NZ, 10'd2, 32'hFFFF_7FFF, 1'b1);
		// close with a pending sum at the low limit, then just below it
		send_word(csm_pkg::FUNC_NZ, 10'd0, 32'h0001_0000, 1'b0);
		send_word(csm_pkg::FUNC_CLOSE, 10'd0, 32'h0000_0000, 1'b0);
		send_word(csm_pkg::FUNC_NZ, 10'd0, 32'h0001_0000, 1'b0);
		send_word(csm_pkg::FUNC_NZ, 10'd2, 32'hFFFF_7FFF, 1'b1);
		// unused code is dropped
		send_word(FUNC_UNUSED, 10'd1023, 32'hFFFF_FFFF, 1'b1);
		send_word(csm_pkg::FUNC_LOAD, 10'd2, 32'hFFFF_FFFF, 1'b0);
		send_word(csm_pkg::FUNC_NZ, 10'd2, 32'h8000_0000, 1'b1);
		send_word(csm_pkg::FUNC_CLOSE, 10'd512, 32'h5555_AAAA, 1'b0);
		s_tvalid <= 1'b0;

		run_phase(11'd1, 0, 0, 106);
		run_phase(11'd7, 57, 0, 106);
		run_phase(11'd1024, 0, 57, 106);
		run_phase(11'd0, 14, 14, 106);
		wait_idle();
		run_phase(11'(sb.row_cnt) + 11'($urandom_range(5, 20)), 0, 0, 106);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d words (%0d loads) over row lengths 3, 1, 7, 1024, 0 and one mid value",
			words_sent, loads_sent);
		$display("checked %0d rows, %0d of them saturated", sb.rows_checked, sb.sat_rows);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
